@@ src/gga_pkg.sv @@
package gga_pkg;

    // Characters kept per field; later characters of the field are dropped.
    localparam int FIELD_CHARS = 10;
    localparam int CHAR_W      = $clog2(FIELD_CHARS + 1);

    // Field numbers (comma count)
    localparam logic [3:0] F_TIME     = 4'd1;
    localparam logic [3:0] F_LAT      = 4'd2;
    localparam logic [3:0] F_NS       = 4'd3;
    localparam logic [3:0] F_LON      = 4'd4;
    localparam logic [3:0] F_EW       = 4'd5;
    localparam logic [3:0] F_FIX      = 4'd6;
    localparam logic [3:0] F_SATS     = 4'd7;
    localparam logic [3:0] F_HDOP     = 4'd8;
    localparam logic [3:0] F_ALT      = 4'd9;
    localparam logic [3:0] F_ALT_UNIT = 4'd10;
    localparam logic [3:0] F_GEO      = 4'd11;
    localparam logic [3:0] F_GEO_UNIT = 4'd12;
    localparam logic [3:0] F_LAST     = 4'd15;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Saturation limits
    localparam int MAX_TIME    = 999999999;
    localparam int MAX_COORD_Q = 999999;   // coordinate / 1000
    localparam int MAX_COORD_R = 999;      // coordinate % 1000
    localparam int MAX_SATS    = 99;
    localparam int MAX_HDOP    = 9999;
    localparam int MAX_ALT     = 99999;

    // floor(x / 1000) == (x * 8389) >> 23 for x < 10000
    localparam int THOUSAND    = 1000;
    localparam int RECIP_1000  = 8389;
    localparam int RECIP_SHIFT = 23;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_sentence;
    } in_t;

    typedef struct packed {
        logic [29:0] utc_time;
        logic [19:0] latitude_whole;
        logic [7:0]  north_south;
        logic [19:0] longitude_whole;
        logic [7:0]  east_west;
        logic [3:0]  fix_kind;
        logic [6:0]  satellite_count;
        logic [13:0] dilution_tenths;
        logic [16:0] altitude_tenths;
        logic [7:0]  altitude_unit;
        logic [16:0] geoid_tenths;
        logic [7:0]  geoid_unit;
    } out_t;

    // Coordinates are held as quotient and remainder by 1000.
    typedef struct packed {
        logic [3:0]        field_number;
        logic [CHAR_W-1:0] chars_in_field;
        logic [29:0]       time_acc;
        logic [19:0]       lat_q;
        logic [9:0]        lat_r;
        logic [19:0]       lon_q;
        logic [9:0]        lon_r;
        logic [7:0]        ns_char;
        logic [7:0]        ew_char;
        logic [3:0]        fix_value;
        logic [6:0]        sat_acc;
        logic              sat_too_long;
        logic [13:0]       hdop_acc;
        logic [16:0]       alt_acc;
        logic              alt_zeroed;
        logic [7:0]        alt_unit_char;
        logic [16:0]       geo_acc;
        logic              geo_zeroed;
        logic [7:0]        geo_unit_char;
    } st_t;

endpackage

@@ src/gga_coord_acc.sv @@
// Decimal coordinate accumulator kept as (q, r) with value = q*1000 + r.
module gga_coord_acc (
    input  logic [19:0] q,
    input  logic [9:0]  r,
    input  logic [3:0]  d,
    output logic [19:0] q_next,
    output logic [9:0]  r_next
);

    logic [13:0] x;
    logic [26:0] prod;
    logic [3:0]  qd;
    logic [13:0] qd_k;
    logic [13:0] rem;
    logic [23:0] nq;

    assign x    = ({4'b0, r} << 3) + ({4'b0, r} << 1) + {10'b0, d};
    assign prod = {13'b0, x} * 27'(gga_pkg::RECIP_1000);
    assign qd   = prod[gga_pkg::RECIP_SHIFT +: 4];
    assign qd_k = {10'b0, qd} * 14'(gga_pkg::THOUSAND);
    assign rem  = x - qd_k;
    assign nq   = ({4'b0, q} << 3) + ({4'b0, q} << 1) + {20'b0, qd};

    always_comb begin
        if (nq > 24'(gga_pkg::MAX_COORD_Q)) begin
            q_next = 20'(gga_pkg::MAX_COORD_Q);
            r_next = 10'(gga_pkg::MAX_COORD_R);
        end else begin
            q_next = nq[19:0];
            r_next = rem[9:0];
        end
    end

endmodule

@@ src/gga_step.sv @@
// Next-state logic for one character, plus the record built from that state.
module gga_step (
    input  gga_pkg::in_t  in_beat,
    input  gga_pkg::st_t  st,
    output gga_pkg::st_t  st_next,
    output gga_pkg::out_t rec
);

    logic [7:0]  c;
    logic        dig;
    logic [3:0]  d;
    logic        pos_zero;
    logic        room;
    logic [19:0] lat_q_n;
    logic [9:0]  lat_r_n;
    logic [19:0] lon_q_n;
    logic [9:0]  lon_r_n;
    logic [33:0] time_x;
    logic [9:0]  sat_x;
    logic [16:0] hdop_x;
    logic [19:0] alt_x;
    logic [19:0] geo_x;
    logic [29:0] time_s;
    logic [6:0]  sat_s;
    logic [13:0] hdop_s;
    logic [16:0] alt_s;
    logic [16:0] geo_s;

    assign c        = in_beat.byte_in;
    assign dig      = c inside {[8'h30:8'h39]};
    assign d        = dig ? 4'(c - gga_pkg::CH_ZERO) : 4'd0;
    assign pos_zero = (st.chars_in_field == '0);
    assign room     = st.chars_in_field < gga_pkg::CHAR_W'(gga_pkg::FIELD_CHARS);

    gga_coord_acc u_lat (
        .q      (st.lat_q),
        .r      (st.lat_r),
        .d      (d),
        .q_next (lat_q_n),
        .r_next (lat_r_n)
    );

    gga_coord_acc u_lon (
        .q      (st.lon_q),
        .r      (st.lon_r),
        .d      (d),
        .q_next (lon_q_n),
        .r_next (lon_r_n)
    );

    // acc*10 + d, then clamp
    assign time_x = ({4'b0, st.time_acc} << 3) + ({4'b0, st.time_acc} << 1) + {30'b0, d};
    assign sat_x  = ({3'b0, st.sat_acc} << 3) + ({3'b0, st.sat_acc} << 1) + {6'b0, d};
    assign hdop_x = ({3'b0, st.hdop_acc} << 3) + ({3'b0, st.hdop_acc} << 1) + {13'b0, d};
    assign alt_x  = ({3'b0, st.alt_acc} << 3) + ({3'b0, st.alt_acc} << 1) + {16'b0, d};
    assign geo_x  = ({3'b0, st.geo_acc} << 3) + ({3'b0, st.geo_acc} << 1) + {16'b0, d};

    assign time_s = (time_x > 34'(gga_pkg::MAX_TIME)) ? 30'(gga_pkg::MAX_TIME) : time_x[29:0];
    assign sat_s  = (sat_x > 10'(gga_pkg::MAX_SATS)) ? 7'(gga_pkg::MAX_SATS) : sat_x[6:0];
    assign hdop_s = (hdop_x > 17'(gga_pkg::MAX_HDOP)) ? 14'(gga_pkg::MAX_HDOP) : hdop_x[13:0];
    assign alt_s  = (alt_x > 20'(gga_pkg::MAX_ALT)) ? 17'(gga_pkg::MAX_ALT) : alt_x[16:0];
    assign geo_s  = (geo_x > 20'(gga_pkg::MAX_ALT)) ? 17'(gga_pkg::MAX_ALT) : geo_x[16:0];

    always_comb begin
        st_next = st;
        if (c == gga_pkg::CH_COMMA) begin
            if (st.field_number != gga_pkg::F_LAST) begin
                st_next.field_number = st.field_number + 4'd1;
            end
            st_next.chars_in_field = '0;
        end else if (room) begin
            st_next.chars_in_field = st.chars_in_field + gga_pkg::CHAR_W'(1);
            case (st.field_number)
                gga_pkg::F_TIME: begin
                    if (dig) st_next.time_acc = time_s;
                end
                gga_pkg::F_LAT: begin
                    if (dig) begin
                        st_next.lat_q = lat_q_n;
                        st_next.lat_r = lat_r_n;
                    end
                end
                gga_pkg::F_NS: begin
                    st_next.ns_char = c;
                end
                gga_pkg::F_LON: begin
                    if (dig) begin
                        st_next.lon_q = lon_q_n;
                        st_next.lon_r = lon_r_n;
                    end
                end
                gga_pkg::F_EW: begin
                    st_next.ew_char = c;
                end
                gga_pkg::F_FIX: begin
                    if (pos_zero) st_next.fix_value = d;
                end
                gga_pkg::F_SATS: begin
                    if (st.chars_in_field >= gga_pkg::CHAR_W'(2)) begin
                        st_next.sat_too_long = 1'b1;
                    end else if (dig) begin
                        st_next.sat_acc = sat_s;
                    end
                end
                gga_pkg::F_HDOP: begin
                    if (dig) st_next.hdop_acc = hdop_s;
                end
                gga_pkg::F_ALT: begin
                    if (pos_zero && c == gga_pkg::CH_ZERO) st_next.alt_zeroed = 1'b1;
                    if (dig) st_next.alt_acc = alt_s;
                end
                gga_pkg::F_ALT_UNIT: begin
                    st_next.alt_unit_char = c;
                end
                gga_pkg::F_GEO: begin
                    if (pos_zero && c == gga_pkg::CH_ZERO) st_next.geo_zeroed = 1'b1;
                    if (dig) st_next.geo_acc = geo_s;
                end
                gga_pkg::F_GEO_UNIT: begin
                    st_next.geo_unit_char = c;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rec.utc_time        = st_next.time_acc;
        rec.latitude_whole  = st_next.lat_q;
        rec.north_south     = st_next.ns_char;
        rec.longitude_whole = st_next.lon_q;
        rec.east_west       = st_next.ew_char;
        rec.fix_kind        = st_next.fix_value;
        rec.satellite_count = st_next.sat_too_long ? 7'd0 : st_next.sat_acc;
        rec.dilution_tenths = st_next.hdop_acc;
        rec.altitude_tenths = st_next.alt_zeroed ? 17'd0 : st_next.alt_acc;
        rec.altitude_unit   = st_next.alt_unit_char;
        rec.geoid_tenths    = st_next.geo_zeroed ? 17'd0 : st_next.geo_acc;
        rec.geoid_unit      = st_next.geo_unit_char;
    end

endmodule

@@ src/nmea_gga_field_parser.sv @@
// GGA sentence field parser.
// Input channel (s_valid/s_ready/s_data): one ASCII character per beat, with
//   end_of_sentence set on the sentence's final character.
// Result channel (m_valid/m_ready/m_data): one record per sentence, sent
//   after the final character has been taken into the field state.
// Characters that are not final produce no beat on the result channel.
// Throughput: one character per cycle while the result side is not stalled.
// Result path: the final character goes through the input register, then the
//   result register, which it enters once the result slot is free.
// Coordinates are kept as quotient/remainder by 1000 while digits arrive,
//   so the record needs no divider; the per-byte path is x10 adds, a
//   narrow reciprocal multiply and a clamp compare.
// Reset (aresetn low, synchronous): field state, input and result valid
//   flags are cleared; a half-received sentence is discarded.
// Stall: while m_valid is high and m_ready low, the held record stays put and
//   the input register stops advancing; s_ready drops once it is full.
module nmea_gga_field_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gga_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gga_pkg::out_t m_data
);

    logic          in_valid_reg;
    gga_pkg::in_t  in_data_reg;
    gga_pkg::st_t  st_reg;
    gga_pkg::st_t  st_next;
    gga_pkg::out_t rec_next;
    logic          out_valid_reg;
    gga_pkg::out_t out_data_reg;
    logic          advance;
    logic          emit;

    // Input beat moves into the field state when the result slot can take a record.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign emit    = advance && in_data_reg.end_of_sentence;
    assign s_ready = !in_valid_reg || advance;

    gga_step u_step (
        .in_beat (in_data_reg),
        .st      (st_reg),
        .st_next (st_next),
        .rec     (rec_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                // final character clears the state for the next sentence
                st_reg <= in_data_reg.end_of_sentence ? '0 : st_next;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (emit) begin
            out_data_reg <= rec_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ src/gga_checker.sv @@
module gga_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input gga_pkg::out_t m_data
);

    // held record must not change under stall
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // clamped coordinates
    a_coord: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.latitude_whole <= 20'd999999
                 && m_data.longitude_whole <= 20'd999999)
        else $error("coordinate out of range");

    a_small: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.fix_kind <= 4'd9 && m_data.satellite_count <= 7'd99)
        else $error("fix or satellite count out of range");

    a_tenths: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.dilution_tenths <= 14'd9999
                 && m_data.altitude_tenths <= 17'd99999
                 && m_data.geoid_tenths <= 17'd99999)
        else $error("tenths value out of range");

endmodule

bind nmea_gga_field_parser gga_checker u_gga_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
